/* rtl/cpa_pkg.sv */
// Shared types, constants and codes of the contiguous page allocator.
`default_nettype none

package cpa_pkg;

	localparam int NUM_PAGES_DEF = 1024;

	localparam int MODE_W = 2;
	localparam int REQ_W  = 11;
	localparam int IDX_W  = 10;
	localparam int RL_W   = 11;

	localparam int APB_DW = 32;
	localparam int ADDR_W = 3;
	localparam int RIDX_W = ADDR_W - 2;

	localparam logic [RIDX_W-1:0] REG_BOOT_RESERVED = RIDX_W'(0);

	localparam logic [MODE_W-1:0] MODE_INIT      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE_RUN  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FREE_PAGE = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request, clear walkers
		logic init_wr;    // write one page of the init pattern
		logic scan;       // first-fit scan step
		logic mark_load;  // record run length, point walker at run base
		logic clr_wr;     // mark one page used
		logic run_rd;     // read and clear recorded length
		logic run_load;   // load remaining count from recorded length
		logic set_wr;     // mark one page free
		logic single_wr;  // free one page, clear its length
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic init_last;
		logic found;
		logic exhausted;
		logic rem_last;
		logic set_end;
		logic req_zero;
		logic idx_ok;
	} sts_t;

	// controller -> result register
	typedef struct packed {
		logic load;
		logic ok;
		logic base_en;
	} res_t;

endpackage

`default_nettype wire

/* rtl/cpa_dp.sv */
// Datapath: free map and run-length memories, scan and walk counters.
`default_nettype none

module cpa_dp #(
	parameter int NUM_PAGES = cpa_pkg::NUM_PAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cpa_pkg::cmd_t              cmd,
	input  logic [cpa_pkg::REQ_W-1:0]  request_pages,
	input  logic [cpa_pkg::IDX_W-1:0]  page_index,
	input  logic [cpa_pkg::REQ_W-1:0]  boot_reserved_pages,
	output cpa_pkg::sts_t              sts,
	output logic [cpa_pkg::IDX_W-1:0]  base_page
);
	import cpa_pkg::*;

	localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW    = $clog2(NUM_PAGES + 1);
	localparam int CMP_W = (CW > REQ_W) ? CW : REQ_W;
	localparam logic [CMP_W-1:0] N_CMP     = CMP_W'(NUM_PAGES);
	localparam logic [CW-1:0]    N_CNT     = CW'(NUM_PAGES);
	localparam logic [CW-1:0]    LAST_CNT  = CW'(NUM_PAGES - 1);
	localparam logic [PW-1:0]    LAST_PAGE = PW'(NUM_PAGES - 1);

	logic              fm_mem [NUM_PAGES];
	logic [RL_W-1:0]   rl_mem [NUM_PAGES];

	logic [REQ_W-1:0]  req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CW-1:0]     ra_q;
	logic [CW-1:0]     walk_q;
	logic [RL_W-1:0]   rem_q;
	logic [REQ_W-1:0]  count_q;
	logic [PW-1:0]     start_q;
	logic              dv_s1;
	logic [PW-1:0]     page_s1;
	logic              fm_rd_s1;
	logic [RL_W-1:0]   rl_rd_s1;

	logic [CMP_W-1:0]  rsv;
	logic              used;
	logic              fm_we;
	logic [PW-1:0]     fm_wa;
	logic              fm_wd;
	logic              rl_we;
	logic [PW-1:0]     rl_wa;
	logic [RL_W-1:0]   rl_wd;
	logic              hit;

	// reserved count saturates at the page count
	assign rsv  = (CMP_W'(boot_reserved_pages) > N_CMP) ? N_CMP : CMP_W'(boot_reserved_pages);
	assign used = CMP_W'(walk_q) < rsv;

	always_comb begin
		fm_we = cmd.init_wr | cmd.clr_wr | cmd.set_wr | cmd.single_wr;
		fm_wa = cmd.single_wr ? PW'(idx_q) : walk_q[PW-1:0];
		fm_wd = cmd.init_wr ? ~used : (cmd.set_wr | cmd.single_wr);

		rl_we = cmd.init_wr | cmd.mark_load | cmd.run_rd | cmd.single_wr;
		priority if (cmd.init_wr) begin
			rl_wa = walk_q[PW-1:0];
			rl_wd = RL_W'(used);
		end else if (cmd.mark_load) begin
			rl_wa = start_q;
			rl_wd = req_q;
		end else begin
			rl_wa = PW'(idx_q);
			rl_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fm_we) begin
			fm_mem[fm_wa] <= fm_wd;
		end
		fm_rd_s1 <= fm_mem[ra_q[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rl_we) begin
			rl_mem[rl_wa] <= rl_wd;
		end
		rl_rd_s1 <= rl_mem[PW'(idx_q)];
	end

	// payload captured with the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request_pages;
			idx_q <= page_index;
		end
	end

	assign hit = cmd.scan & dv_s1 & fm_rd_s1 & (count_q + REQ_W'(1) == req_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1   <= 1'b0;
			ra_q    <= '0;
			count_q <= '0;
			walk_q  <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.load) begin
				dv_s1   <= 1'b0;
				ra_q    <= '0;
				count_q <= '0;
				walk_q  <= '0;
			end else if (cmd.scan) begin
				dv_s1 <= ra_q < N_CNT;
				if (ra_q < N_CNT) begin
					ra_q <= ra_q + CW'(1);
				end
				if (dv_s1) begin
					count_q <= fm_rd_s1 ? count_q + REQ_W'(1) : '0;
				end
			end else begin
				dv_s1 <= 1'b0;
			end

			if (cmd.init_wr || cmd.clr_wr || cmd.set_wr) begin
				walk_q <= walk_q + CW'(1);
			end else if (cmd.mark_load) begin
				walk_q <= CW'(start_q);
			end else if (cmd.run_rd) begin
				walk_q <= CW'(idx_q);
			end

			if (cmd.mark_load) begin
				rem_q <= req_q;
			end else if (cmd.run_load) begin
				rem_q <= rl_rd_s1;
			end else if (cmd.clr_wr || cmd.set_wr) begin
				rem_q <= rem_q - RL_W'(1);
			end
		end
	end

	// scan pipeline address and run base
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			page_s1 <= ra_q[PW-1:0];
			if (dv_s1 && fm_rd_s1 && count_q == '0) begin
				start_q <= page_s1;
			end
		end
	end

	always_comb begin
		sts.init_last = walk_q == LAST_CNT;
		sts.found     = hit;
		sts.exhausted = cmd.scan & dv_s1 & ~hit & (page_s1 == LAST_PAGE);
		sts.rem_last  = rem_q == RL_W'(1);
		sts.set_end   = (rem_q == '0) || (walk_q >= N_CNT);
		sts.req_zero  = req_q == '0;
		sts.idx_ok    = CMP_W'(idx_q) < N_CMP;
	end

	assign base_page = IDX_W'(start_q);

	a_clr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> walk_q < N_CNT)
		else $error("run marking walked past the last page");

endmodule

`default_nettype wire

/* rtl/cpa_ctrl.sv */
// Controller: sequences init, first-fit scan, run marking and frees.
`default_nettype none

module cpa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [cpa_pkg::MODE_W-1:0] mode,
	input  logic                       out_free,
	input  cpa_pkg::sts_t              sts,
	output cpa_pkg::cmd_t              cmd,
	output cpa_pkg::res_t              res
);
	import cpa_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_INIT  = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_MLOAD = 4'd4;
	localparam logic [3:0] ST_MARK  = 4'd5;
	localparam logic [3:0] ST_RUNRD = 4'd6;
	localparam logic [3:0] ST_RUNLD = 4'd7;
	localparam logic [3:0] ST_SET   = 4'd8;
	localparam logic [3:0] ST_RESP  = 4'd9;

	logic [3:0]        state_q, state_d;
	logic [MODE_W-1:0] mode_q;
	logic              active_q, active_d;
	logic              ok_q, ok_d;
	logic              base_en_q, base_en_d;

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		state_d     = state_q;
		active_d    = active_q;
		ok_d        = ok_q;
		base_en_d   = base_en_q;
		cmd         = '0;
		res.load    = 1'b0;
		res.ok      = ok_q;
		res.base_en = base_en_q;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				ok_d      = 1'b0;
				base_en_d = 1'b0;
				state_d   = ST_RESP;
				unique case (mode_q)
					MODE_INIT: begin
						if (!active_q) state_d = ST_INIT;
					end
					MODE_ALLOC: begin
						if (active_q && !sts.req_zero) state_d = ST_SCAN;
					end
					MODE_FREE_RUN: begin
						if (active_q && sts.idx_ok) state_d = ST_RUNRD;
					end
					MODE_FREE_PAGE: begin
						if (active_q && sts.idx_ok) begin
							cmd.single_wr = 1'b1;
							ok_d          = 1'b1;
						end
					end
				endcase
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					active_d = 1'b1;
					ok_d     = 1'b1;
					state_d  = ST_RESP;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found) begin
					state_d = ST_MLOAD;
				end else if (sts.exhausted) begin
					state_d = ST_RESP;
				end
			end
			ST_MLOAD: begin
				cmd.mark_load = 1'b1;
				state_d       = ST_MARK;
			end
			ST_MARK: begin
				cmd.clr_wr = 1'b1;
				if (sts.rem_last) begin
					ok_d      = 1'b1;
					base_en_d = 1'b1;
					state_d   = ST_RESP;
				end
			end
			ST_RUNRD: begin
				cmd.run_rd = 1'b1;
				state_d    = ST_RUNLD;
			end
			ST_RUNLD: begin
				cmd.run_load = 1'b1;
				state_d      = ST_SET;
			end
			ST_SET: begin
				if (sts.set_end) begin
					ok_d    = 1'b1;
					state_d = ST_RESP;
				end else begin
					cmd.set_wr = 1'b1;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					res.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 1'b0;
			ok_q      <= 1'b0;
			base_en_q <= 1'b0;
			mode_q    <= MODE_INIT;
		end else begin
			state_q   <= state_d;
			active_q  <= active_d;
			ok_q      <= ok_d;
			base_en_q <= base_en_d;
			if (cmd.load) begin
				mode_q <= mode;
			end
		end
	end

	a_found_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.found) |=> state_q == ST_MLOAD)
		else $error("found run not followed by marking");

	a_init_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_wr |-> !active_q)
		else $error("init pattern written while allocator active");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> out_free)
		else $error("result loaded over an untaken word");

endmodule

`default_nettype wire

/* rtl/contiguous_page_allocator.sv */
// Top level: first-fit contiguous page allocator with stream ports and APB config.
//
// One word in, one word out; a new request is taken only once the previous one is done.
// Init writes one page a cycle into the free map and the run-length memory. Allocate
// scans the free map one page a cycle through its single registered read port and gives
// up once the last page is scanned with no run found; marking then loads the run base
// and clears one allocated page a cycle. Free-run frees the recorded length of pages,
// clipped at the last page. Free-page, a zero-page request, a second init and any
// request while inactive go straight from dispatch to the reply. A reply still waiting
// for the sink holds the next one in its reply state. The memories have no clearing
// pass after reset: until init runs the allocator is inactive, every request is
// answered without touching them, and init writes every entry before any is used.
`default_nettype none

module contiguous_page_allocator #(
	parameter int NUM_PAGES = cpa_pkg::NUM_PAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,   // [10:0] request_pages, [20:11] page_index
	input  logic [1:0]                  s_tuser,   // [1:0] mode
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // [9:0] base_page
	output logic [0:0]                  m_tuser,   // [0] success
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cpa_pkg::ADDR_W-1:0]  paddr,
	input  logic [cpa_pkg::APB_DW-1:0]  pwdata,
	output logic [cpa_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import cpa_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	res_t              res;
	logic [IDX_W-1:0]  dp_base;
	logic [REQ_W-1:0]  boot_q;
	logic              out_free;
	logic              m_tvalid_q;
	logic              ok_q;
	logic [IDX_W-1:0]  base_q;
	logic [RIDX_W-1:0] reg_idx;

	// config: one register, boot_reserved_pages at byte 0
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_BOOT_RESERVED) begin
			boot_q <= pwdata[REQ_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_BOOT_RESERVED) ? APB_DW'(boot_q) : '0;

	// result register keeps the input side free while a word waits
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			ok_q   <= res.ok;
			base_q <= res.base_en ? dp_base : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = 16'(base_q);

	cpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser[MODE_W-1:0]),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.res      (res)
	);

	cpa_dp #(
		.NUM_PAGES (NUM_PAGES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.request_pages       (s_tdata[REQ_W-1:0]),
		.page_index          (s_tdata[REQ_W+IDX_W-1:REQ_W]),
		.boot_reserved_pages (boot_q),
		.sts                 (sts),
		.base_page           (dp_base)
	);

	a_fail_zero_base: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tdata == '0)
		else $error("failed operation returned a nonzero base page");

endmodule

`default_nettype wire
